/* rtl/assert_macros.svh */
// Assertion macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define CHK_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed");

// Property checked on every edge, reset included.
`define CHK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

/* rtl/lut3d_pkg.sv */
// Shared types and constants of the 3D LUT color mapper.
package lut3d_pkg;

   localparam int CHANNEL_BITS = 16;
   localparam int FRAC         = CHANNEL_BITS - 2;
   localparam int ONE_VAL      = 1 << FRAC;
   localparam int MAX_GRID     = 33;
   localparam int SIZE_BITS    = 6;
   localparam int IDX_BITS     = $clog2(MAX_GRID);
   localparam int NN_BITS      = $clog2(MAX_GRID * MAX_GRID + 1);
   localparam int DEPTH        = MAX_GRID * MAX_GRID * MAX_GRID;
   localparam int ADDR_BITS    = $clog2(DEPTH);
   localparam int ENTRY_BITS   = 16;
   localparam int CORNERS      = 8;
   localparam int PROD_BITS    = CHANNEL_BITS + FRAC + 2;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic REG_LUT_SIZE = 1'b0;

   typedef logic signed [CHANNEL_BITS-1:0] chan_type;
   typedef chan_type [2:0]                 rgb_type;
   typedef logic [FRAC-1:0]                frac_type;
   typedef logic [IDX_BITS-1:0]            idx_type;
   typedef logic [SIZE_BITS-1:0]           size_type;
   typedef logic [NN_BITS-1:0]             nn_type;
   typedef logic [ADDR_BITS-1:0]           addr_type;
   typedef logic [ENTRY_BITS-1:0]          entry_type;

   typedef struct packed {
      idx_type  i0;
      idx_type  i1;
      frac_type fr;
   } axis_type;

   typedef struct packed {
      logic      load;
      logic      pass;
      rgb_type   raw;
      entry_type eidx;
   } tag_type;

   typedef struct packed {
      logic            pass;
      rgb_type         raw;
      frac_type [2:0]  fr;
   } side_type;

   // a + round(f*(b-a) / 2^FRAC), halves toward plus infinity
   function automatic chan_type lerp(chan_type a, chan_type b, frac_type f);
      logic signed [CHANNEL_BITS:0] d;
      logic signed [PROD_BITS-1:0]  p;
      logic signed [PROD_BITS-1:0]  q;
      d = CHANNEL_BITS'(0) + ((CHANNEL_BITS+1)'(b) - (CHANNEL_BITS+1)'(a));
      p = $signed(PROD_BITS'(d)) * $signed(PROD_BITS'({1'b0, f}));
      p = p + $signed(PROD_BITS'(ONE_VAL / 2));
      q = p >>> FRAC;
      return a + q[CHANNEL_BITS-1:0];
   endfunction

endpackage

/* rtl/lut3d_ram.sv */
// Generic simple dual-port RAM with registered read.
module lut3d_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 35937
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

/* rtl/lut3d_prep.sv */
// Clamp, scale and split of the three channels into grid index and fraction.
module lut3d_prep (
   input  logic                          clock,
   input  logic                          en,
   input  lut3d_pkg::rgb_type            pix,
   input  lut3d_pkg::idx_type            nm1,
   output lut3d_pkg::axis_type [2:0]     axes_ff
);

   localparam int SB = lut3d_pkg::FRAC + 1 + lut3d_pkg::IDX_BITS;

   lut3d_pkg::axis_type [2:0] axes_in;

   always_comb begin
      logic [lut3d_pkg::FRAC:0]         cl;
      logic [SB-1:0]                    s;
      logic [lut3d_pkg::IDX_BITS:0]     hi;
      logic [lut3d_pkg::IDX_BITS:0]     inc;
      lut3d_pkg::idx_type               i0;
      for (int k = 0; k < 3; k++) begin
         if (pix[k] < 0) begin
            cl = '0;
         end else if (pix[k] > lut3d_pkg::ONE_VAL) begin
            cl = (lut3d_pkg::FRAC+1)'(lut3d_pkg::ONE_VAL);
         end else begin
            cl = pix[k][lut3d_pkg::FRAC:0];
         end
         s  = SB'(cl) * SB'(nm1);
         hi = s[SB-1:lut3d_pkg::FRAC];
         if (hi > {1'b0, nm1}) begin
            i0 = nm1;
         end else begin
            i0 = hi[lut3d_pkg::IDX_BITS-1:0];
         end
         inc = {1'b0, i0} + (lut3d_pkg::IDX_BITS+1)'(1);
         axes_in[k].i0 = i0;
         axes_in[k].i1 = (inc < {1'b0, nm1}) ? inc[lut3d_pkg::IDX_BITS-1:0] : nm1;
         axes_in[k].fr = s[lut3d_pkg::FRAC-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axes_ff <= axes_in;
      end
   end

endmodule

/* rtl/lut3d_addr.sv */
// Flat table addresses of the eight cube corners, or the write address of a load.
module lut3d_addr (
   input  logic                                       clock,
   input  logic                                       en,
   input  lut3d_pkg::axis_type [2:0]                  axes,
   input  lut3d_pkg::size_type                        n,
   input  lut3d_pkg::nn_type                          nn,
   input  logic                                       load,
   input  lut3d_pkg::entry_type                       eidx,
   output lut3d_pkg::addr_type [lut3d_pkg::CORNERS-1:0] addr_ff
);

   localparam int AW = lut3d_pkg::ADDR_BITS;

   lut3d_pkg::addr_type [lut3d_pkg::CORNERS-1:0] addr_in;

   always_comb begin
      lut3d_pkg::idx_type ri;
      lut3d_pkg::idx_type gi;
      lut3d_pkg::idx_type bi;
      for (int c = 0; c < lut3d_pkg::CORNERS; c++) begin
         ri = ((c & 4) != 0) ? axes[0].i1 : axes[0].i0;
         gi = ((c & 2) != 0) ? axes[1].i1 : axes[1].i0;
         bi = ((c & 1) != 0) ? axes[2].i1 : axes[2].i0;
         if (load) begin
            addr_in[c] = AW'(eidx);
         end else begin
            addr_in[c] = AW'(ri) * AW'(nn) + AW'(gi) * AW'(n) + AW'(bi);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         addr_ff <= addr_in;
      end
   end

endmodule

/* rtl/lut3d_lerp.sv */
// One registered stage of parallel linear interpolations.
module lut3d_lerp #(
   parameter int LANES = 4
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  lut3d_pkg::chan_type [LANES-1:0]      a,
   input  lut3d_pkg::chan_type [LANES-1:0]      b,
   input  lut3d_pkg::frac_type [LANES-1:0]      f,
   output lut3d_pkg::chan_type [LANES-1:0]      q_ff
);

   lut3d_pkg::chan_type [LANES-1:0] q_in;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         q_in[l] = lut3d_pkg::lerp(a[l], b[l], f[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

endmodule

/* rtl/lut3d_trilinear_color_map.sv */
// Top level of the 3D LUT color mapper with trilinear interpolation.
// One item per clock while rsp_ready lets the pipe advance; an accepted pixel passes
// through prep, address, table read, then red, green and blue interpolation stages. Each
// stage holds while the next one is full and stalled, so bubbles close up under a stall.
// The table is kept in eight copies of 35937 x 48 bits, one per cube corner,
// all written by each load item at its read stage; entries are undefined until
// loaded and there is no clearing pass. Load items give no result and indices
// at or above 35937 are dropped. lut_size above 33 acts as 33; lut_size 0
// returns the pixel unchanged with passed_through set. Write lut_size only idle.
module lut3d_trilinear_color_map (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [15:0]                    req_red,
   input  logic signed [15:0]                    req_green,
   input  logic signed [15:0]                    req_blue,
   input  logic [15:0]                           req_entry_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [15:0]                    rsp_out_red,
   output logic signed [15:0]                    rsp_out_green,
   output logic signed [15:0]                    rsp_out_blue,
   output logic                                  rsp_passed_through,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [lut3d_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int NC = lut3d_pkg::CORNERS;

   lut3d_pkg::size_type lut_size_ff;
   lut3d_pkg::size_type nsat;
   lut3d_pkg::idx_type  nm1;
   lut3d_pkg::nn_type   nn_ff;

   logic [6:1] v_ff;
   logic [7:1] adv;

   lut3d_pkg::rgb_type  pix;
   lut3d_pkg::tag_type  tag1_ff;
   lut3d_pkg::tag_type  tag2_ff;
   lut3d_pkg::frac_type [2:0] fr2_ff;
   lut3d_pkg::side_type side3_ff;
   lut3d_pkg::side_type side4_ff;
   lut3d_pkg::side_type side5_ff;
   lut3d_pkg::side_type side6_ff;

   lut3d_pkg::axis_type [2:0]  axes;
   lut3d_pkg::addr_type [NC-1:0] addr;
   lut3d_pkg::rgb_type  [NC-1:0] rd;
   logic                         we;

   lut3d_pkg::chan_type [11:0] a4, b4, q4;
   lut3d_pkg::frac_type [11:0] f4;
   lut3d_pkg::chan_type [5:0]  a5, b5, q5;
   lut3d_pkg::frac_type [5:0]  f5;
   lut3d_pkg::chan_type [2:0]  a6, b6, q6;
   lut3d_pkg::frac_type [2:0]  f6;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         lut_size_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == lut3d_pkg::REG_LUT_SIZE) begin
         lut_size_ff <= csr_pwdata[lut3d_pkg::SIZE_BITS-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == lut3d_pkg::REG_LUT_SIZE) ? 32'(lut_size_ff) : '0;

   assign nsat = (lut_size_ff > lut3d_pkg::SIZE_BITS'(lut3d_pkg::MAX_GRID))
                 ? lut3d_pkg::SIZE_BITS'(lut3d_pkg::MAX_GRID) : lut_size_ff;
   assign nm1  = lut3d_pkg::IDX_BITS'(nsat - lut3d_pkg::SIZE_BITS'(1));

   always_ff @(posedge clock) begin
      nn_ff <= lut3d_pkg::NN_BITS'(nsat) * lut3d_pkg::NN_BITS'(nsat);
   end

   // pipeline control
   assign adv[7] = rsp_ready;
   assign adv[6] = !v_ff[6] || adv[7];
   assign adv[5] = !v_ff[5] || adv[6];
   assign adv[4] = !v_ff[4] || adv[5];
   assign adv[3] = !v_ff[3] || adv[4];
   assign adv[2] = !v_ff[2] || adv[3];
   assign adv[1] = !v_ff[1] || adv[2];

   assign req_ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) v_ff[1] <= req_valid;
         if (adv[2]) v_ff[2] <= v_ff[1];
         if (adv[3]) v_ff[3] <= v_ff[2] && !tag2_ff.load;
         if (adv[4]) v_ff[4] <= v_ff[3];
         if (adv[5]) v_ff[5] <= v_ff[4];
         if (adv[6]) v_ff[6] <= v_ff[5];
      end
   end

   assign pix[0] = req_red;
   assign pix[1] = req_green;
   assign pix[2] = req_blue;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         tag1_ff.load <= req_mode;
         tag1_ff.pass <= (lut_size_ff == '0);
         tag1_ff.raw  <= pix;
         tag1_ff.eidx <= req_entry_index;
      end
      if (adv[2]) begin
         tag2_ff <= tag1_ff;
         for (int k = 0; k < 3; k++) begin
            fr2_ff[k] <= axes[k].fr;
         end
      end
      if (adv[3]) begin
         side3_ff.pass <= tag2_ff.pass;
         side3_ff.raw  <= tag2_ff.raw;
         side3_ff.fr   <= fr2_ff;
      end
      if (adv[4]) side4_ff <= side3_ff;
      if (adv[5]) side5_ff <= side4_ff;
      if (adv[6]) side6_ff <= side5_ff;
   end

   lut3d_prep u_prep (
      .clock   (clock),
      .en      (adv[1]),
      .pix     (pix),
      .nm1     (nm1),
      .axes_ff (axes)
   );

   lut3d_addr u_addr (
      .clock   (clock),
      .en      (adv[2]),
      .axes    (axes),
      .n       (nsat),
      .nn      (nn_ff),
      .load    (tag1_ff.load),
      .eidx    (tag1_ff.eidx),
      .addr_ff (addr)
   );

   assign we = v_ff[2] && tag2_ff.load && adv[3] && (tag2_ff.eidx < lut3d_pkg::DEPTH);

   for (genvar c = 0; c < NC; c++) begin : g_bank
      lut3d_ram #(
         .WIDTH ($bits(lut3d_pkg::rgb_type)),
         .DEPTH (lut3d_pkg::DEPTH)
      ) u_ram (
         .clock    (clock),
         .we       (we),
         .waddr    (lut3d_pkg::ADDR_BITS'(tag2_ff.eidx)),
         .wdata    (tag2_ff.raw),
         .re       (adv[3]),
         .raddr    (addr[c]),
         .rdata_ff (rd[c])
      );
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 4; j++) begin
            a4[k*4+j] = rd[j][k];
            b4[k*4+j] = rd[j+4][k];
            f4[k*4+j] = side3_ff.fr[0];
         end
         for (int m = 0; m < 2; m++) begin
            a5[k*2+m] = q4[k*4+m];
            b5[k*2+m] = q4[k*4+m+2];
            f5[k*2+m] = side4_ff.fr[1];
         end
         a6[k] = q5[k*2];
         b6[k] = q5[k*2+1];
         f6[k] = side5_ff.fr[2];
      end
   end

   lut3d_lerp #(.LANES(12)) u_lerp_r (
      .clock (clock), .en (adv[4]), .a (a4), .b (b4), .f (f4), .q_ff (q4)
   );

   lut3d_lerp #(.LANES(6)) u_lerp_g (
      .clock (clock), .en (adv[5]), .a (a5), .b (b5), .f (f5), .q_ff (q5)
   );

   lut3d_lerp #(.LANES(3)) u_lerp_b (
      .clock (clock), .en (adv[6]), .a (a6), .b (b6), .f (f6), .q_ff (q6)
   );

   assign rsp_valid          = v_ff[6];
   assign rsp_passed_through = side6_ff.pass;
   assign rsp_out_red        = side6_ff.pass ? side6_ff.raw[0] : q6[0];
   assign rsp_out_green      = side6_ff.pass ? side6_ff.raw[1] : q6[1];
   assign rsp_out_blue       = side6_ff.pass ? side6_ff.raw[2] : q6[2];

endmodule

/* rtl/lut3d_checker.sv */
// Port-level checks of the 3D LUT color mapper and their bind.
`include "assert_macros.svh"

module lut3d_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_out_red,
   input logic               csr_pready
);

   `CHK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)
   `CHK_ALWAYS(a_csr_ready, clock, csr_pready)
   `CHK_PROP(a_empty_accepts, clock, reset, !rsp_valid |-> req_ready)
   `CHK_PROP(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_red))

endmodule

bind lut3d_trilinear_color_map lut3d_checker u_lut3d_checker (.*);

/* dv/lut3d_trilinear_color_map_test.sv */
// Testbench for the 3D LUT color mapper: table walk plus random stimulus checked by a predictor.
`timescale 1ns / 100ps

module lut3d_trilinear_color_map_test;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_LOAD  = 1'b1;

   typedef struct {
      lut3d_pkg::chan_type r;
      lut3d_pkg::chan_type g;
      lut3d_pkg::chan_type b;
      logic                pass;
   } pixel_out_type;

   typedef struct {
      int                   size;
      logic                 mode;
      lut3d_pkg::chan_type  r;
      lut3d_pkg::chan_type  g;
      lut3d_pkg::chan_type  b;
      lut3d_pkg::entry_type idx;
      bit                   typed;
      pixel_out_type        want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   lut3d_pkg::chan_type req_red = '0;
   lut3d_pkg::chan_type req_green = '0;
   lut3d_pkg::chan_type req_blue = '0;
   lut3d_pkg::entry_type req_entry_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   lut3d_pkg::chan_type rsp_out_red, rsp_out_green, rsp_out_blue;
   logic rsp_passed_through;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [lut3d_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lut3d_pkg::chan_type lut_copy [0:lut3d_pkg::DEPTH-1][0:2];
   bit                  written [0:lut3d_pkg::DEPTH-1];
   int                  cur_size;
   pixel_out_type       pending [$];
   int                  errors = 0;
   int                  send_idle = 28;
   int                  recv_idle = 56;
   int                  win = 0;

   lut3d_trilinear_color_map dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic lut3d_pkg::chan_type blend(longint a, longint b, longint f);
      longint p;
      p = f * (b - a) + lut3d_pkg::ONE_VAL / 2;
      return lut3d_pkg::chan_type'(a + (p >>> lut3d_pkg::FRAC));
   endfunction

   function automatic int grid_n();
      return (cur_size > lut3d_pkg::MAX_GRID) ? lut3d_pkg::MAX_GRID : cur_size;
   endfunction

   function automatic void split_axis(input longint cin, input int n, output int lo,
                                      output int hi, output longint f);
      longint v, s;
      v = cin;
      if (v < 0) v = 0;
      if (v > lut3d_pkg::ONE_VAL) v = lut3d_pkg::ONE_VAL;
      s = v * (n - 1);
      lo = int'(s >>> lut3d_pkg::FRAC);
      f = s & (lut3d_pkg::ONE_VAL - 1);
      if (lo > n - 1) lo = n - 1;
      hi = (lo + 1 < n - 1) ? lo + 1 : n - 1;
   endfunction

   function automatic int corner_index(int lo [3], int hi [3], int n, int j);
      int ri, gi, bi;
      ri = j[2] ? hi[0] : lo[0];
      gi = j[1] ? hi[1] : lo[1];
      bi = j[0] ? hi[2] : lo[2];
      return ri * n * n + gi * n + bi;
   endfunction

   function automatic pixel_out_type map_pixel(lut3d_pkg::chan_type r, lut3d_pkg::chan_type g,
                                               lut3d_pkg::chan_type b);
      pixel_out_type o;
      longint cin [3];
      longint fr [3];
      int i0 [3];
      int i1 [3];
      longint c [8];
      longint c00, c01, c10, c11, c0, c1;
      lut3d_pkg::chan_type res [3];
      int n, k, j;
      n = grid_n();
      if (n == 0) begin
         o.r = r; o.g = g; o.b = b; o.pass = 1'b1;
         return o;
      end
      cin[0] = r; cin[1] = g; cin[2] = b;
      for (k = 0; k < 3; k++) begin
         split_axis(cin[k], n, i0[k], i1[k], fr[k]);
      end
      for (k = 0; k < 3; k++) begin
         for (j = 0; j < 8; j++) begin
            c[j] = lut_copy[corner_index(i0, i1, n, j)][k];
         end
         c00 = blend(c[0], c[4], fr[0]);
         c01 = blend(c[1], c[5], fr[0]);
         c10 = blend(c[2], c[6], fr[0]);
         c11 = blend(c[3], c[7], fr[0]);
         c0 = blend(c00, c10, fr[1]);
         c1 = blend(c01, c11, fr[1]);
         res[k] = blend(c0, c1, fr[2]);
      end
      o.r = res[0]; o.g = res[1]; o.b = res[2]; o.pass = 1'b0;
      return o;
   endfunction

   function automatic lut3d_pkg::chan_type rand_chan();
      case ($urandom_range(7))
         0, 1: return lut3d_pkg::chan_type'($urandom_range(16'hffff));
         2: return '0;
         3: return lut3d_pkg::chan_type'(lut3d_pkg::ONE_VAL);
         4: return lut3d_pkg::chan_type'(-32768);
         5: return lut3d_pkg::chan_type'(32767);
         default: return lut3d_pkg::chan_type'($urandom_range(lut3d_pkg::ONE_VAL));
      endcase
   endfunction

   // clamped or corner values: grid index 0 or n-1 only
   function automatic lut3d_pkg::chan_type edge_chan();
      case ($urandom_range(4))
         0: return lut3d_pkg::chan_type'(-32768);
         1: return lut3d_pkg::chan_type'(-int'($urandom_range(32767, 1)));
         2: return '0;
         3: return lut3d_pkg::chan_type'(lut3d_pkg::ONE_VAL);
         default: return lut3d_pkg::chan_type'(
                            int'($urandom_range(32767, lut3d_pkg::ONE_VAL + 1)));
      endcase
   endfunction

   // value whose grid index is exactly a
   function automatic lut3d_pkg::chan_type cell_chan(int n, int a);
      int t;
      if (n < 2) return lut3d_pkg::chan_type'($urandom_range(16'hffff));
      t = int'($urandom_range(lut3d_pkg::ONE_VAL - 1, n - 1));
      return lut3d_pkg::chan_type'((a * lut3d_pkg::ONE_VAL + t) / (n - 1));
   endfunction

   function automatic void rand_pixel(output lut3d_pkg::chan_type r, output lut3d_pkg::chan_type g,
                                      output lut3d_pkg::chan_type b);
      int n;
      n = grid_n();
      if ($urandom_range(3) == 0) begin
         r = edge_chan(); g = edge_chan(); b = edge_chan();
      end else begin
         r = cell_chan(n, win); g = cell_chan(n, win); b = cell_chan(n, win);
      end
   endfunction

   task automatic drive(logic mode, lut3d_pkg::chan_type r, lut3d_pkg::chan_type g,
                        lut3d_pkg::chan_type b, lut3d_pkg::entry_type idx, pixel_out_type want);
      bit acc;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_entry_index <= idx;
      do begin
         @(negedge clock);
         acc = req_valid && req_ready;
         @(posedge clock);
      end while (!acc);
      if (mode == MODE_LOAD) begin
         if (idx < lut3d_pkg::DEPTH) begin
            lut_copy[idx][0] = r; lut_copy[idx][1] = g; lut_copy[idx][2] = b;
            written[idx] = 1'b1;
         end
      end else begin
         pending = {pending, want};
      end
   endtask

   // load every corner the pixel will read that has not been loaded yet
   task automatic fill_corners(lut3d_pkg::chan_type r, lut3d_pkg::chan_type g,
                               lut3d_pkg::chan_type b);
      longint cin [3];
      longint fr [3];
      int i0 [3];
      int i1 [3];
      int n, k, j, e;
      pixel_out_type none;
      none = '{'0, '0, '0, 1'b0};
      n = grid_n();
      if (n == 0) return;
      cin[0] = r; cin[1] = g; cin[2] = b;
      for (k = 0; k < 3; k++) begin
         split_axis(cin[k], n, i0[k], i1[k], fr[k]);
      end
      for (j = 0; j < 8; j++) begin
         e = corner_index(i0, i1, n, j);
         if (!written[e])
            drive(MODE_LOAD, rand_chan(), rand_chan(), rand_chan(),
                  lut3d_pkg::entry_type'(e), none);
      end
   endtask

   task automatic send(logic mode, lut3d_pkg::chan_type r, lut3d_pkg::chan_type g,
                       lut3d_pkg::chan_type b, lut3d_pkg::entry_type idx,
                       bit typed, pixel_out_type want);
      pixel_out_type w;
      w = want;
      if (mode == MODE_PIXEL) begin
         fill_corners(r, g, b);
         if (!typed) w = map_pixel(r, g, b);
      end
      drive(mode, r, g, b, idx, w);
   endtask

   // drain results, then let load items still in the pipe retire
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_size(int value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {lut3d_pkg::REG_LUT_SIZE, 2'b00}; csr_pwdata <= 32'(value);
      @(posedge clock) csr_penable <= 1'b1;
      @(posedge clock) begin
         csr_pwrite <= 1'b0; csr_penable <= 1'b0;
      end
      @(posedge clock) csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[lut3d_pkg::SIZE_BITS-1:0] != value[lut3d_pkg::SIZE_BITS-1:0])
         report_mismatch("lut_size readback", csr_prdata, value);
      @(posedge clock) begin
         csr_psel <= 1'b0; csr_penable <= 1'b0;
      end
      cur_size = value;
   endtask

   always @(negedge clock) begin
      pixel_out_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            report_mismatch("unexpected item", rsp_out_red, 0);
         end else begin
            w = pending.pop_front();
            if (rsp_out_red != w.r) report_mismatch("out_red", rsp_out_red, w.r);
            if (rsp_out_green != w.g) report_mismatch("out_green", rsp_out_green, w.g);
            if (rsp_out_blue != w.b) report_mismatch("out_blue", rsp_out_blue, w.b);
            if (rsp_passed_through != w.pass)
               report_mismatch("passed_through", rsp_passed_through, w.pass);
         end
      end
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      row_type rows [$];
      pixel_out_type none;
      int sizes [8];
      lut3d_pkg::chan_type pr, pg, pb;
      int i, p, k, n;
      none = '{'0, '0, '0, 1'b0};
      sizes = '{2, 33, 63, 1, 3, 17, 0, 5};
      rows = '{
         '{0, MODE_PIXEL, -32768, 32767, 0, 0, 1, '{-32768, 32767, 0, 1'b1}},
         '{0, MODE_PIXEL, 16384, -1, 20000, 0, 1, '{16384, -1, 20000, 1'b1}},
         '{0, MODE_PIXEL, 32767, -32768, -16384, 16'hffff, 1, '{32767, -32768, -16384, 1'b1}},
         '{0, MODE_LOAD, 1, 2, 3, 35937, 0, none},
         '{0, MODE_LOAD, 4, 5, 6, 16'hffff, 0, none},
         '{0, MODE_LOAD, -32768, 32767, 0, 35936, 0, none},
         '{1, MODE_LOAD, 100, 200, 300, 0, 0, none},
         '{1, MODE_PIXEL, 9000, -5, 32767, 0, 1, '{100, 200, 300, 1'b0}},
         '{1, MODE_PIXEL, 16384, 16384, 16384, 0, 1, '{100, 200, 300, 1'b0}},
         '{2, MODE_LOAD, 1234, -5678, 32767, 7, 0, none},
         '{2, MODE_PIXEL, 16384, 16384, 16384, 0, 1, '{1234, -5678, 32767, 1'b0}},
         '{2, MODE_PIXEL, 0, 0, 0, 0, 0, none},
         '{2, MODE_PIXEL, 8192, 8192, 8192, 0, 0, none},
         '{2, MODE_PIXEL, 1, 16383, 8191, 0, 0, none},
         '{33, MODE_PIXEL, 16384, 16384, 16384, 0, 0, none},
         '{33, MODE_PIXEL, 16383, 16383, 16383, 0, 0, none},
         '{33, MODE_PIXEL, -32768, -1, 32767, 0, 0, none},
         '{33, MODE_PIXEL, 20000, 512, 12345, 0, 0, none},
         '{63, MODE_PIXEL, 16384, 0, 7777, 0, 0, none},
         '{63, MODE_PIXEL, 4096, 16000, -300, 0, 0, none}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_size(0);
      for (i = 0; i < rows.size(); i++) begin
         if (rows[i].size != cur_size) begin
            wait_idle();
            write_size(rows[i].size);
         end
         send(rows[i].mode, rows[i].r, rows[i].g, rows[i].b, rows[i].idx,
              rows[i].typed, rows[i].want);
      end
      k = 0;
      for (p = 0; p < 8; p++) begin
         wait_idle();
         write_size(sizes[p]);
         n = grid_n();
         win = (n >= 2) ? int'($urandom_range(n - 2)) : 0;
         for (i = 0; i < 45; i++) begin
            if (k < 120) begin
               send_idle = 28; recv_idle = 56;
            end else if (k < 240) begin
               send_idle = 56; recv_idle = 28;
            end else begin
               send_idle = 0; recv_idle = 0;
            end
            if ($urandom_range(4) == 0) begin
               send(MODE_LOAD, rand_chan(), rand_chan(), rand_chan(),
                    ($urandom_range(9) == 0)
                       ? lut3d_pkg::entry_type'($urandom_range(16'hffff))
                       : lut3d_pkg::entry_type'($urandom_range(lut3d_pkg::DEPTH - 1)),
                    0, none);
            end else begin
               rand_pixel(pr, pg, pb);
               send(MODE_PIXEL, pr, pg, pb,
                    lut3d_pkg::entry_type'($urandom_range(16'hffff)), 0, none);
            end
            k++;
         end
      end
      wait_idle();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* lut3d_trilinear_color_map.f */
+incdir+rtl
rtl/lut3d_pkg.sv
rtl/lut3d_ram.sv
rtl/lut3d_prep.sv
rtl/lut3d_addr.sv
rtl/lut3d_lerp.sv
rtl/lut3d_trilinear_color_map.sv
rtl/lut3d_checker.sv
dv/lut3d_trilinear_color_map_test.sv
